### rtl/lhte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhte_pkg
// Shared types and constants of the linear history temperature estimator.
// ----------------------------------------------------------------------------
package lhte_pkg;

	localparam int IDX_W = 6;
	localparam int VAL_W = 16;
	localparam int CFG_W = 4;
	localparam int CNT_W = 4;
	localparam int NUM_W = 8;   // common width for comparing small counts
	localparam int FRAC_SHIFT = 14;
	localparam int ROUND_HALF = 8192;

	localparam logic [CNT_W-1:0] SEEN_MAX = 4'd15;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_COEF   = 2'd1;
	localparam logic [1:0] OP_THRESH = 2'd2;
	localparam logic [1:0] OP_OFFSET = 2'd3;

	localparam logic [1:0] CFG_SENSOR_COUNT  = 2'd0;
	localparam logic [1:0] CFG_HISTORY_ORDER = 2'd1;
	localparam logic [1:0] CFG_OFFSET_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		CMD_STAGE  = 3'd0,
		CMD_COMMIT = 3'd1,
		CMD_DROP   = 3'd2,
		CMD_COEF   = 3'd3,
		CMD_THRESH = 3'd4,
		CMD_OFFSET = 3'd5
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [IDX_W-1:0]         idx;
		logic signed [VAL_W-1:0]  value;
	} q_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] sensor_count;
		logic [CFG_W-1:0] history_order;
		logic [CFG_W-1:0] offset_count;
	} cfg_t;

endpackage

### rtl/lhte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lhte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lhte_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhte_queue
// Short first-in first-out queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module lhte_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lhte_pkg::q_entry_t  push_data,
	input  logic                pop,
	output lhte_pkg::q_entry_t  pop_data,
	output logic                full,
	output logic                empty
);
	import lhte_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/lhte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhte_front
// Accepts input requests, counts vector elements and classifies each request
// into a command for the back end.
// ----------------------------------------------------------------------------
module lhte_front #(
	parameter int MAX_SENSORS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [lhte_pkg::IDX_W-1:0]          index,
	input  logic signed [lhte_pkg::VAL_W-1:0]   load_value,
	input  logic                                last_sensor,
	input  logic [lhte_pkg::CFG_W-1:0]          sensor_count,
	input  logic                                q_full,
	output logic                                q_push,
	output lhte_pkg::q_entry_t                  q_data
);
	import lhte_pkg::*;

	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_next;
	logic             bad_count;

	assign in_stall  = q_full;
	assign q_push    = in_valid && !q_full;
	assign seen_next = (seen_q == SEEN_MAX) ? SEEN_MAX : seen_q + 1'b1;
	assign bad_count = (sensor_count == '0)
		|| (NUM_W'(sensor_count) > NUM_W'(MAX_SENSORS))
		|| (NUM_W'(seen_next) != NUM_W'(sensor_count));

	always_comb begin
		q_data.idx   = index;
		q_data.value = load_value;
		case (opcode)
			OP_SAMPLE: begin
				if (!last_sensor) begin
					q_data.cmd = CMD_STAGE;
				end else if (bad_count) begin
					q_data.cmd = CMD_DROP;
				end else begin
					q_data.cmd = CMD_COMMIT;
				end
			end
			OP_COEF:   q_data.cmd = CMD_COEF;
			OP_THRESH: q_data.cmd = CMD_THRESH;
			OP_OFFSET: q_data.cmd = CMD_OFFSET;
			default:   q_data.cmd = CMD_STAGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (q_push && opcode == OP_SAMPLE) begin
			seen_q <= last_sensor ? '0 : seen_next;
		end
	end

endmodule

### rtl/lhte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhte_back
// Executes queued commands: table loads, staging, history commit,
// multiply-accumulate over the history, offset lookup, rounding and output.
// ----------------------------------------------------------------------------
module lhte_back #(
	parameter int MAX_SENSORS = 8,
	parameter int MAX_ORDER   = 8,
	parameter int MAX_OFFSETS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lhte_pkg::cfg_t                      cfg,
	input  logic                                q_empty,
	input  lhte_pkg::q_entry_t                  q_data,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lhte_pkg::VAL_W-1:0]   estimate,
	output logic                                status,
	output logic                                saturated
);
	import lhte_pkg::*;

	localparam int SW     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int OW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int NCOEF  = MAX_ORDER * MAX_SENSORS;
	localparam int CAW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
	localparam int HAW    = OW + SW;
	localparam int HDEPTH = 1 << HAW;
	localparam int ORW    = $clog2(MAX_ORDER + 1);
	localparam int OCW    = $clog2(MAX_OFFSETS + 1);
	localparam int OIW    = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
	localparam int PRW    = 2 * VAL_W;
	localparam int ACC_W  = PRW + $clog2(NCOEF + 1);
	localparam int TOT_W  = ACC_W + 1;
	localparam int RW     = TOT_W - FRAC_SHIFT;

	localparam logic signed [RW-1:0] EST_MAX = RW'(32767);
	localparam logic signed [RW-1:0] EST_MIN = RW'(-32768);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FILL   = 8'b0000_0010,
		ST_MAC    = 8'b0000_0100,
		ST_DRAIN  = 8'b0000_1000,
		ST_SEARCH = 8'b0001_0000,
		ST_SUM    = 8'b0010_0000,
		ST_ROUND  = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [VAL_W-1:0] staging_q [MAX_SENSORS];
	logic signed [VAL_W-1:0] thresh_q  [MAX_OFFSETS];
	logic signed [VAL_W-1:0] offval_q  [MAX_OFFSETS];

	logic              primed_q;
	logic [OW-1:0]     write_slot_q;
	logic [OW-1:0]     slot_q;
	logic [ORW-1:0]    ord_q;
	logic              fill_all_q;
	logic [OW-1:0]     fill_slot_q;
	logic [SW-1:0]     sen_q;
	logic [OW-1:0]     lvl_q;
	logic [OW-1:0]     lag_q;
	logic [CAW-1:0]    step_q;
	logic              v_s1;
	logic              v_s2;
	logic signed [PRW-1:0]   prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [OCW-1:0]          off_i_q;
	logic signed [VAL_W-1:0] off_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [VAL_W-1:0] res_est_q;
	logic                    res_status_q;
	logic                    res_sat_q;

	// ram ports
	logic                    coef_we;
	logic [CAW-1:0]          coef_waddr;
	logic signed [VAL_W-1:0] coef_rd;
	logic                    hist_we;
	logic [HAW-1:0]          hist_waddr;
	logic [HAW-1:0]          hist_raddr;
	logic signed [VAL_W-1:0] hist_rd;

	// derived control values
	logic [ORW-1:0]          ord_eff;
	logic [OW-1:0]           slot_eff;
	logic [OW-1:0]           slot_next;
	logic [OCW-1:0]          oc_eff;
	logic                    sen_last;
	logic                    lag_last;
	logic                    fill_last_slot;
	logic [OIW-1:0]          off_sel;
	logic signed [ACC_W-1:0] thresh_sh;
	logic signed [RW-1:0]    est_raw;
	logic                    out_load;
	logic                    idx_sensor_ok;
	logic                    idx_coef_ok;
	logic                    idx_offset_ok;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign idx_sensor_ok = NUM_W'(q_data.idx) < NUM_W'(MAX_SENSORS);
	assign idx_coef_ok   = (NUM_W + 1)'(q_data.idx) < (NUM_W + 1)'(NCOEF);
	assign idx_offset_ok = NUM_W'(q_data.idx) < NUM_W'(MAX_OFFSETS);

	always_comb begin
		if (cfg.history_order == '0) begin
			ord_eff = ORW'(1);
		end else if (NUM_W'(cfg.history_order) > NUM_W'(MAX_ORDER)) begin
			ord_eff = ORW'(MAX_ORDER);
		end else begin
			ord_eff = ORW'(cfg.history_order);
		end
		if (NUM_W'(cfg.offset_count) > NUM_W'(MAX_OFFSETS)) begin
			oc_eff = OCW'(MAX_OFFSETS);
		end else begin
			oc_eff = OCW'(cfg.offset_count);
		end
	end

	assign slot_eff  = (NUM_W'(write_slot_q) < NUM_W'(ord_eff)) ? write_slot_q : '0;
	assign slot_next = (NUM_W'(slot_eff) + NUM_W'(1) >= NUM_W'(ord_eff)) ?
		'0 : slot_eff + 1'b1;

	assign sen_last       = (NUM_W'(sen_q) + NUM_W'(1)) == NUM_W'(cfg.sensor_count);
	assign lag_last       = (NUM_W'(lag_q) + NUM_W'(1)) == NUM_W'(ord_q);
	assign fill_last_slot = !fill_all_q
		|| ((NUM_W'(fill_slot_q) + NUM_W'(1)) == NUM_W'(ord_q));

	assign off_sel   = OIW'(off_i_q - 1'b1);
	assign thresh_sh = ACC_W'(thresh_q[off_sel]) <<< FRAC_SHIFT;
	assign est_raw   = total_q[TOT_W-1:FRAC_SHIFT];

	// coefficient table writes come only from queued loads
	assign coef_we    = q_pop && q_data.cmd == CMD_COEF && idx_coef_ok;
	assign coef_waddr = CAW'(q_data.idx);

	assign hist_we    = (state_q == ST_FILL);
	assign hist_waddr = {fill_slot_q, sen_q};
	assign hist_raddr = {lvl_q, sen_q};

	lhte_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NCOEF)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (q_data.value),
		.raddr (step_q),
		.rdata (coef_rd)
	);

	lhte_ram #(
		.WIDTH (VAL_W),
		.DEPTH (HDEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (staging_q[sen_q]),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	assign out_load = (state_q == ST_EMIT) && (!out_valid || !out_stall);

	// table and staging stores
	always_ff @(posedge clk) begin
		if (q_pop) begin
			case (q_data.cmd)
				CMD_STAGE, CMD_COMMIT, CMD_DROP: begin
					if (idx_sensor_ok) begin
						staging_q[SW'(q_data.idx)] <= q_data.value;
					end
				end
				CMD_THRESH: begin
					if (idx_offset_ok) begin
						thresh_q[OIW'(q_data.idx)] <= q_data.value;
					end
				end
				CMD_OFFSET: begin
					if (idx_offset_ok) begin
						offval_q[OIW'(q_data.idx)] <= q_data.value;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= coef_rd * hist_rd;
		end
		case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
				if (q_pop && q_data.cmd == CMD_DROP) begin
					res_est_q    <= '0;
					res_status_q <= 1'b1;
					res_sat_q    <= 1'b0;
				end
			end
			ST_MAC, ST_DRAIN: begin
				if (v_s2) begin
					acc_q <= acc_q + ACC_W'(prod_s2);
				end
				off_q <= '0;
			end
			ST_SEARCH: begin
				if (off_i_q != '0 && thresh_sh < acc_q) begin
					off_q <= offval_q[off_sel];
				end
			end
			ST_SUM: begin
				total_q <= TOT_W'(acc_q) + (TOT_W'(off_q) <<< FRAC_SHIFT)
					+ TOT_W'(ROUND_HALF);
			end
			ST_ROUND: begin
				res_status_q <= 1'b0;
				if (est_raw > EST_MAX) begin
					res_est_q <= VAL_W'(EST_MAX);
					res_sat_q <= 1'b1;
				end else if (est_raw < EST_MIN) begin
					res_est_q <= VAL_W'(EST_MIN);
					res_sat_q <= 1'b1;
				end else begin
					res_est_q <= VAL_W'(est_raw);
					res_sat_q <= 1'b0;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			estimate  <= res_est_q;
			status    <= res_status_q;
			saturated <= res_sat_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			primed_q     <= 1'b0;
			write_slot_q <= '0;
			slot_q       <= '0;
			ord_q        <= ORW'(1);
			fill_all_q   <= 1'b0;
			fill_slot_q  <= '0;
			sen_q        <= '0;
			lvl_q        <= '0;
			lag_q        <= '0;
			step_q       <= '0;
			off_i_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_data.cmd == CMD_DROP) begin
						state_q <= ST_EMIT;
					end else if (q_pop && q_data.cmd == CMD_COMMIT) begin
						// the first vector fills every slot of the history
						slot_q       <= slot_eff;
						ord_q        <= ord_eff;
						fill_all_q   <= !primed_q;
						fill_slot_q  <= primed_q ? slot_eff : '0;
						sen_q        <= '0;
						primed_q     <= 1'b1;
						write_slot_q <= slot_next;
						state_q      <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!sen_last) begin
						sen_q <= sen_q + 1'b1;
					end else if (!fill_last_slot) begin
						sen_q       <= '0;
						fill_slot_q <= fill_slot_q + 1'b1;
					end else begin
						sen_q   <= '0;
						lvl_q   <= slot_q;
						lag_q   <= '0;
						step_q  <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					// walk lags newest first, wrapping below slot zero
					step_q <= step_q + 1'b1;
					if (!sen_last) begin
						sen_q <= sen_q + 1'b1;
					end else begin
						sen_q <= '0;
						lag_q <= lag_q + 1'b1;
						lvl_q <= (lvl_q == '0) ? OW'(ord_q - 1'b1) : lvl_q - 1'b1;
						if (lag_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						off_i_q <= oc_eff;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// highest entry whose threshold is below the sum wins
					if (off_i_q == '0 || thresh_sh < acc_q) begin
						state_q <= ST_SUM;
					end else begin
						off_i_q <= off_i_q - 1'b1;
					end
				end
				ST_SUM: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/linear_history_temp_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_history_temp_estimator
// Weighted sum over a history of sensor vectors plus a threshold offset.
// ----------------------------------------------------------------------------
// Requests enter a front end that counts vector elements and classifies each
// request, then wait in a four-entry queue for the back end, so input is taken
// while the back end computes or a result waits on the output, until the queue
// fills. Coefficient and offset loads and non-final elements are handled without
// leaving the back end's idle state. A vector with a wrong element count goes
// from the queue straight to the emit state, which registers its status result
// at the output. A committed vector makes sensor_count history writes
// (history_order * sensor_count on the first vector, which fills every slot),
// then history_order * sensor_count multiply-accumulates at one product a cycle
// through the single-port-read history and coefficient RAMs, a pipeline drain, a
// threshold search over up to offset_count entries, and rounding and output.
// ----------------------------------------------------------------------------
module linear_history_temp_estimator #(
	parameter int MAX_SENSORS = 8,
	parameter int MAX_ORDER   = 8,
	parameter int MAX_OFFSETS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [1:0]                          cfg_index,
	input  logic [lhte_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [lhte_pkg::IDX_W-1:0]          index,
	input  logic signed [lhte_pkg::VAL_W-1:0]   load_value,
	input  logic                                last_sensor,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lhte_pkg::VAL_W-1:0]   estimate,
	output logic                                status,
	output logic                                saturated
);
	import lhte_pkg::*;

	cfg_t     cfg_q;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	q_entry_t q_in;
	q_entry_t q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_count  <= CFG_W'(1);
			cfg_q.history_order <= CFG_W'(1);
			cfg_q.offset_count  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SENSOR_COUNT:  cfg_q.sensor_count  <= cfg_data;
				CFG_HISTORY_ORDER: cfg_q.history_order <= cfg_data;
				CFG_OFFSET_COUNT:  cfg_q.offset_count  <= cfg_data;
				default: ;
			endcase
		end
	end

	lhte_front #(
		.MAX_SENSORS (MAX_SENSORS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.index        (index),
		.load_value   (load_value),
		.last_sensor  (last_sensor),
		.sensor_count (cfg_q.sensor_count),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	lhte_queue #(
		.DEPTH (4)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	lhte_back #(
		.MAX_SENSORS (MAX_SENSORS),
		.MAX_ORDER   (MAX_ORDER),
		.MAX_OFFSETS (MAX_OFFSETS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.estimate  (estimate),
		.status    (status),
		.saturated (saturated)
	);

endmodule
